// File: hw/rtl/ortf_pkg.sv
// Shared types, operation codes and status codes for the ordered route table.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package ortf_pkg;

  // Default number of route cells in the chain
  localparam int DEFAULT_DEPTH = 16;

  localparam int ADDR_W   = 32;
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int TTL_W    = 8;
  localparam int STATUS_W = 3;

  // Operation codes carried in mode
  localparam logic [MODE_W-1:0] MODE_LOOKUP    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEL_INDEX = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_MATCH = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROUTE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TTL_EXPIRED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd5;

  // Next hop of zero means directly connected
  localparam logic [ADDR_W-1:0] DIRECT_HOP = 32'h0000_0000;

  // One route entry
  typedef struct packed {
    logic [ADDR_W-1:0] network;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
  } entry_t;

  // Request fields every cell compares against during a scan
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] net_mask;
  } req_t;

  // Search probe handed from cell to cell
  typedef struct packed {
    logic              live;
    logic              found;
    logic [ADDR_W-1:0] gateway;
  } probe_t;

  // Table update command broadcast to all cells
  typedef struct packed {
    logic   shift_en;
    logic   write_en;
    entry_t wdata;
  } cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/ortf_cell.sv
// One route cell: holds a single table entry, matches it against the probe
// passing by, and shifts toward cell 0 when an earlier entry is removed. Uses ortf_pkg.
`default_nettype none
module ortf_cell #(
  parameter int DEPTH = ortf_pkg::DEFAULT_DEPTH,
  parameter int INDEX = 0,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  ortf_pkg::req_t       req,
  input  ortf_pkg::cmd_t       cmd,
  input  wire  [CW-1:0]        count,
  input  wire  [IW-1:0]        shift_pos,
  input  ortf_pkg::entry_t     ent_in,
  output ortf_pkg::entry_t     ent_out,
  input  ortf_pkg::probe_t     probe_in,
  input  wire  [IW-1:0]        pos_in,
  output ortf_pkg::probe_t     probe_out,
  output logic [IW-1:0]        pos_out
);
  import ortf_pkg::*;

  entry_t entry;
  logic   in_table;
  logic   hit;
  logic   take;

  assign ent_out  = entry;
  assign in_table = (CW'(INDEX) < count);

  // Compare this entry: masked match for lookup, exact match for delete
  always_comb begin
    if (req.mode == MODE_LOOKUP) begin
      hit = in_table && ((req.address & entry.mask) == (entry.network & entry.mask));
    end else begin
      hit = in_table && (entry.network == req.address) && (entry.mask == req.net_mask);
    end
  end

  assign take = probe_in.live && !probe_in.found && hit;

  // Hold the entry; shift up from the next cell or load an appended route
  always_ff @(posedge clk) begin
    if (cmd.shift_en && (IW'(INDEX) >= shift_pos)) begin
      entry <= ent_in;
    end else if (cmd.write_en && (CW'(INDEX) == count)) begin
      entry <= cmd.wdata;
    end
  end

  // Advance the probe one cell, claiming it on the first hit
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.live <= 1'b0;
    end else begin
      probe_out.live <= probe_in.live;
    end
    if (take) begin
      probe_out.found   <= 1'b1;
      probe_out.gateway <= entry.gateway;
      pos_out           <= IW'(INDEX);
    end else begin
      probe_out.found   <= probe_in.found;
      probe_out.gateway <= probe_in.gateway;
      pos_out           <= pos_in;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ordered_route_table_forwarder_core.sv
// Top level of the ordered route table: request control, entry count and a
// chain of ortf_cell route cells. Uses ortf_pkg.
`default_nettype none
// Each request is taken when start is high and busy is low, and gives exactly
// one result, shown for one cycle with done high; the receiver cannot stall,
// so the result must be captured in that cycle. Add and delete-by-index do not
// enter the scan state: done follows on the next cycle and busy stays low, so
// these may be issued every cycle. Lookup and delete-by-match send a search
// probe down the chain of DEPTH route cells, one cell per cycle, and the first
// matching cell claims it; busy stays high until the probe leaves the last cell,
// done rises as busy falls, and no new request is taken until the scan ends.
// Removals close the gap by shifting all later cells up by one.
// Entries beyond the current count are never read, so no clearing is needed.
module ordered_route_table_forwarder_core #(
  parameter int DEPTH = ortf_pkg::DEFAULT_DEPTH
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire  [ortf_pkg::MODE_W-1:0]      mode,
  input  wire  [ortf_pkg::ADDR_W-1:0]      address,
  input  wire  [ortf_pkg::ADDR_W-1:0]      net_mask,
  input  wire  [ortf_pkg::ADDR_W-1:0]      hop_address,
  input  wire  [ortf_pkg::INDEX_W-1:0]     entry_index,
  input  wire  [ortf_pkg::TTL_W-1:0]       hop_limit,
  output logic                             done,
  output logic [ortf_pkg::STATUS_W-1:0]    status,
  output logic [ortf_pkg::ADDR_W-1:0]      forward_address,
  output logic [ortf_pkg::TTL_W-1:0]       new_hop_limit,
  output logic [ortf_pkg::INDEX_W-1:0]     hit_position
);
  import ortf_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic          state, state_next;
  logic          launch, launch_next;
  logic [CW-1:0] count, count_next;
  req_t          req;
  logic [TTL_W-1:0] ttl;
  logic          accept;

  cmd_t          cmd;
  logic [IW-1:0] shift_pos;

  logic                done_next;
  logic [STATUS_W-1:0] status_next;
  logic [ADDR_W-1:0]   forward_next;
  logic [TTL_W-1:0]    ttl_next;
  logic [INDEX_W-1:0]  hit_next;

  probe_t        probe [DEPTH+1];
  logic [IW-1:0] pos   [DEPTH+1];
  entry_t        ent   [DEPTH+1];

  assign busy   = (state == S_SCAN);
  assign accept = start && !busy;

  // Inject the probe from the launch register, set at the edge that latches the request
  assign probe[0].live    = launch;
  assign probe[0].found   = 1'b0;
  assign probe[0].gateway = DIRECT_HOP;
  assign pos[0]           = '0;
  assign ent[DEPTH]       = '0;

  // Cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ortf_cell #(
      .DEPTH (DEPTH),
      .INDEX (g),
      .IW    (IW),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .req       (req),
      .cmd       (cmd),
      .count     (count),
      .shift_pos (shift_pos),
      .ent_in    (ent[g+1]),
      .ent_out   (ent[g]),
      .probe_in  (probe[g]),
      .pos_in    (pos[g]),
      .probe_out (probe[g+1]),
      .pos_out   (pos[g+1])
    );
  end

  // Decide table updates and the result of the request in flight
  always_comb begin
    state_next        = state;
    launch_next       = 1'b0;
    count_next        = count;
    cmd.shift_en      = 1'b0;
    cmd.write_en      = 1'b0;
    cmd.wdata.network = address;
    cmd.wdata.mask    = net_mask;
    cmd.wdata.gateway = hop_address;
    shift_pos         = IW'(entry_index);
    done_next         = 1'b0;
    status_next       = ST_OK;
    forward_next      = '0;
    ttl_next          = '0;
    hit_next          = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_ADD: begin
              done_next = 1'b1;
              if (32'(count) >= 32'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                cmd.write_en = 1'b1;
                count_next   = count + CW'(1);
              end
            end
            MODE_DEL_INDEX: begin
              done_next = 1'b1;
              if (32'(entry_index) >= 32'(count)) begin
                status_next = ST_BAD_INDEX;
              end else begin
                cmd.shift_en = 1'b1;
                count_next   = count - CW'(1);
              end
            end
            default: begin
              state_next  = S_SCAN;
              launch_next = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        shift_pos = pos[DEPTH];
        if (probe[DEPTH].live) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          if (req.mode == MODE_LOOKUP) begin
            if (!probe[DEPTH].found) begin
              status_next = ST_NO_ROUTE;
            end else if (ttl <= TTL_W'(1)) begin
              status_next = ST_TTL_EXPIRED;
            end else begin
              forward_next = (probe[DEPTH].gateway == DIRECT_HOP) ? req.address
                                                                  : probe[DEPTH].gateway;
              ttl_next     = ttl - TTL_W'(1);
              hit_next     = INDEX_W'(pos[DEPTH]);
            end
          end else if (probe[DEPTH].found) begin
            cmd.shift_en = 1'b1;
            count_next   = count - CW'(1);
          end else begin
            status_next = ST_NOT_FOUND;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      launch <= 1'b0;
      count  <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
      count  <= count_next;
      done   <= done_next;
    end
  end

  // Latch request fields and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req.mode     <= mode;
      req.address  <= address;
      req.net_mask <= net_mask;
      ttl          <= hop_limit;
    end
    status          <= status_next;
    forward_address <= forward_next;
    new_hop_limit   <= ttl_next;
    hit_position    <= hit_next;
  end

`ifndef ASSERT_OFF
  // Entry count never exceeds the number of cells
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(DEPTH))
    else $error("route count exceeds table depth");

  // A probe only leaves the chain while a scan is in progress
  a_probe_in_scan: assert property (@(posedge clk) disable iff (rst)
    probe[DEPTH].live |-> busy)
    else $error("probe left the chain outside a scan");

  // Finishing a scan always presents a result
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("scan ended without a result");
`endif

endmodule
`default_nettype wire
